### rtl/sfq_pkg.sv
package sfq_pkg;

  // queue geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int DATA_W   = 32;
  localparam int POSOUT_W = 4;
  localparam int MCOUNT_W = 5;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic load;    // take the pushed word
    logic shift;   // take the neighbour's word (pop)
    logic search;  // capture the compare result
    logic valid;   // cell holds a live entry
  } sfq_cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } sfq_state_t;

endpackage

### rtl/searchable_fifo_queue.sv
// Channel   Signals                                  Handshake
// command   cmd, value, index                        taken when start && !busy
// result    data, found, position, match_count,      one cycle, marked by done
//           fill_level, status
//
// Entries sit in a row of cells ordered from the head; pop shifts the row by one.
// For push, pop, read and clear, done follows the accepting edge.
// Search: the cells compare in a first step, the match vector is reduced to flag,
// first position and count in a second step (state ST_SEARCH); busy is high then.
// rst (synchronous) empties the queue; cell contents are not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
module searchable_fifo_queue import sfq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [VALUE_W-1:0]  value,
  input  logic [INDEX_W-1:0]  index,
  output logic                done,
  output logic [DATA_W-1:0]   data,
  output logic                found,
  output logic [POSOUT_W-1:0] position,
  output logic [MCOUNT_W-1:0] match_count,
  output logic [FILL_W-1:0]   fill_level,
  output logic [STATUS_W-1:0] status
);

  sfq_state_t state, state_next;
  logic [CNT_W-1:0] fill, fill_next;

  word_t          cell_word [DEPTH];
  logic [DEPTH-1:0] cell_match;
  sfq_cell_ctrl_t cell_ctrl [DEPTH];
  word_t          key;

  logic             accept, push_ok, pop_ok, read_oor;
  logic             red_found;
  logic [POS_W-1:0] red_first;
  logic [CNT_W-1:0] red_total;

  logic                res_load, done_next, found_next;
  logic [DATA_W-1:0]   data_next;
  logic [POSOUT_W-1:0] position_next;
  logic [MCOUNT_W-1:0] match_count_next;
  logic [STATUS_W-1:0] status_next;

  assign key      = DATA_WIDTH'(value);
  assign accept   = start && !busy;
  assign push_ok  = accept && (cmd == CMD_PUSH) && (fill != CNT_W'(DEPTH));
  assign pop_ok   = accept && (cmd == CMD_POP) && (fill != '0);
  assign read_oor = 32'(index) >= 32'(fill);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load   = push_ok && (fill == CNT_W'(i));
      cell_ctrl[i].shift  = pop_ok;
      cell_ctrl[i].search = accept && (cmd == CMD_SEARCH);
      cell_ctrl[i].valid  = CNT_W'(i) < fill;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = cell_word[g];
    end else begin : g_mid
      assign nbr = cell_word[g+1];
    end
    sfq_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[g]),
      .din   (key),
      .nbr   (nbr),
      .key   (key),
      .word  (cell_word[g]),
      .match (cell_match[g])
    );
  end

  sfq_match_reduce u_reduce (
    .match (cell_match),
    .found (red_found),
    .first (red_first),
    .total (red_total)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_SEARCH)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and result
  always_comb begin
    busy             = (state == ST_SEARCH);
    fill_next        = fill;
    data_next        = '0;
    found_next       = 1'b0;
    position_next    = '0;
    match_count_next = '0;
    status_next      = STAT_OK;
    res_load         = 1'b0;
    if (state == ST_SEARCH) begin
      res_load         = 1'b1;
      found_next       = red_found;
      position_next    = POSOUT_W'(red_first);
      match_count_next = MCOUNT_W'(red_total);
    end else if (accept) begin
      res_load = (cmd != CMD_SEARCH);
      unique case (cmd)
        CMD_PUSH: begin
          if (push_ok) begin
            fill_next = fill + 1'b1;
          end else begin
            status_next = STAT_FULL;
          end
        end
        CMD_POP: begin
          if (pop_ok) begin
            data_next = DATA_W'(cell_word[0]);
            fill_next = fill - 1'b1;
          end else begin
            status_next = STAT_EMPTY;
          end
        end
        CMD_READ: begin
          if (read_oor) begin
            status_next = STAT_EMPTY;
          end else begin
            data_next = DATA_W'(cell_word[POS_W'(index)]);
          end
        end
        CMD_CLEAR: fill_next = '0;
        default: ;
      endcase
    end
    done_next = res_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data        <= data_next;
      found       <= found_next;
      position    <= position_next;
      match_count <= match_count_next;
      fill_level  <= FILL_W'(fill_next);
      status      <= status_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_search_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("search phase longer than one cycle");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy && cmd != CMD_SEARCH) || $past(busy)))
    else $error("result without a command behind it");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (fill_level == FILL_W'(DEPTH)))
    else $error("full flagged on a queue that is not full");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (match_count != '0))
    else $error("found without matches");

endmodule

### rtl/sfq_cell.sv
module sfq_cell import sfq_pkg::*; (
  input  logic           clk,
  input  sfq_cell_ctrl_t ctrl,
  input  word_t          din,
  input  word_t          nbr,
  input  word_t          key,
  output word_t          word,
  output logic           match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= din;
    end else if (ctrl.shift) begin
      word <= nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.search) begin
      match <= ctrl.valid && (word == key);
    end
  end

endmodule

### rtl/sfq_match_reduce.sv
module sfq_match_reduce import sfq_pkg::*; (
  input  logic [DEPTH-1:0] match,
  output logic             found,
  output logic [POS_W-1:0] first,
  output logic [CNT_W-1:0] total
);

  always_comb begin
    first = '0;
    // lowest set bit wins: scan from the top so the lowest is written last
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first = POS_W'(i);
      end
    end
    found = |match;
    total = CNT_W'($countones(match));
  end

endmodule
